### hdl/rlmtf_pkg.sv
`default_nettype none

package rlmtf_pkg;

  // list geometry
  localparam int unsigned HistoryDepth = 64;
  localparam int unsigned TableSize    = 4096;

  localparam int unsigned KeyW   = $clog2(TableSize);
  localparam int unsigned AddrW  = $clog2(HistoryDepth);
  localparam int unsigned CountW = $clog2(HistoryDepth + 1);
  localparam int unsigned FieldW = 7;

  // command codes
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FRONT,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

### hdl/recency_list_move_to_front.sv
`default_nettype none

// move-to-front recency list of table indices. a word is taken when start is
// high and busy is low; cmd selects push (move or insert the key at the front)
// or query (report its position only). exactly one result word follows per
// command: done is high for one cycle with position (-1 when absent, the place
// before this command otherwise), list_count (entries after this command) and
// accepted (low only when a new key met a full list). the receiver cannot
// stall, so results must be taken in the cycle done is high. the keys live in
// one memory with one read and one write port and a registered read; a search
// streams through the listed entries one per cycle, and a move or insert then
// walks the affected entries back one place, one per cycle. the longest
// command is a move from the back of a full list. no clearing pass is
// needed after reset.
module recency_list_move_to_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               cmd,
  input  wire logic [rlmtf_pkg::KeyW-1:0]         entry_index,
  output logic                                    done,
  output logic signed [rlmtf_pkg::FieldW-1:0]     position,
  output logic [rlmtf_pkg::FieldW-1:0]            list_count,
  output logic                                    accepted
);
  import rlmtf_pkg::*;

  // key store, front of the list at address zero
  logic [KeyW-1:0]  mem [HistoryDepth];
  logic [KeyW-1:0]  rdata;
  logic [AddrW-1:0] mem_raddr;
  logic [AddrW-1:0] mem_waddr;
  logic [KeyW-1:0]  mem_wdata;
  logic             mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // control and working registers
  state_t            state, state_next;
  logic              cmd_q, cmd_q_next;
  logic [KeyW-1:0]   key_q, key_q_next;
  logic [CountW-1:0] count, count_next;
  logic [CountW-1:0] rd_ptr, rd_ptr_next;     // next entry to fetch in search
  logic              chk_valid, chk_valid_next; // rdata holds a fetched entry
  logic [AddrW-1:0]  chk_idx, chk_idx_next;   // address of that entry
  logic [AddrW-1:0]  pos_q, pos_q_next;
  logic              found_q, found_q_next;
  logic              acc_q, acc_q_next;
  logic [AddrW-1:0]  wr_ptr, wr_ptr_next;     // destination during shift
  logic              pend, pend_next;         // shift read in flight

  logic hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q     <= cmd_q_next;
    key_q     <= key_q_next;
    rd_ptr    <= rd_ptr_next;
    chk_valid <= chk_valid_next;
    chk_idx   <= chk_idx_next;
    pos_q     <= pos_q_next;
    found_q   <= found_q_next;
    acc_q     <= acc_q_next;
    wr_ptr    <= wr_ptr_next;
    pend      <= pend_next;
  end

  assign hit = chk_valid && (rdata == key_q);

  always_comb begin
    state_next     = state;
    cmd_q_next     = cmd_q;
    key_q_next     = key_q;
    count_next     = count;
    rd_ptr_next    = rd_ptr;
    chk_valid_next = chk_valid;
    chk_idx_next   = chk_idx;
    pos_q_next     = pos_q;
    found_q_next   = found_q;
    acc_q_next     = acc_q;
    wr_ptr_next    = wr_ptr;
    pend_next      = pend;
    mem_raddr      = '0;
    mem_waddr      = '0;
    mem_wdata      = key_q;
    mem_we         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_q_next     = cmd;
          key_q_next     = entry_index;
          rd_ptr_next    = '0;
          chk_valid_next = 1'b0;
          found_q_next   = 1'b0;
          acc_q_next     = 1'b1;
          state_next     = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        // fetch one entry a cycle, compare the one fetched last cycle
        if (rd_ptr < count) begin
          mem_raddr      = rd_ptr[AddrW-1:0];
          rd_ptr_next    = rd_ptr + CountW'(1);
          chk_valid_next = 1'b1;
          chk_idx_next   = rd_ptr[AddrW-1:0];
        end else begin
          chk_valid_next = 1'b0;
        end

        if (hit) begin
          found_q_next = 1'b1;
          pos_q_next   = chk_idx;
          if ((cmd_q == CMD_QUERY) || (chk_idx == '0)) begin
            state_next = ST_RESULT;
          end else begin
            wr_ptr_next = chk_idx;
            pend_next   = 1'b0;
            state_next  = ST_SHIFT;
          end
        end else if (rd_ptr == count) begin
          // every listed entry compared, key absent
          found_q_next = 1'b0;
          if (cmd_q == CMD_QUERY) begin
            state_next = ST_RESULT;
          end else if (count == CountW'(HistoryDepth)) begin
            acc_q_next = 1'b0;
            state_next = ST_RESULT;
          end else begin
            count_next  = count + CountW'(1);
            wr_ptr_next = count[AddrW-1:0];
            pend_next   = 1'b0;
            if (count == '0) begin
              state_next = ST_FRONT;
            end else begin
              state_next = ST_SHIFT;
            end
          end
        end
      end

      ST_SHIFT: begin
        // copy entry wr_ptr-1 into wr_ptr, walking toward the front
        if (!pend) begin
          mem_raddr = wr_ptr - AddrW'(1);
          pend_next = 1'b1;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = wr_ptr;
          mem_wdata   = rdata;
          wr_ptr_next = wr_ptr - AddrW'(1);
          if (wr_ptr == AddrW'(1)) begin
            pend_next  = 1'b0;
            state_next = ST_FRONT;
          end else begin
            mem_raddr = wr_ptr - AddrW'(2);
          end
        end
      end

      ST_FRONT: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = key_q;
        state_next = ST_RESULT;
      end

      ST_RESULT: begin
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result word, held in registers while done is high
  assign busy       = (state != ST_IDLE);
  assign done       = (state == ST_RESULT);
  assign position   = found_q ? FieldW'(pos_q) : '1;
  assign list_count = FieldW'(count);
  assign accepted   = acc_q;

endmodule

`default_nettype wire

### hdl/rlmtf_checker.sv
`default_nettype none

module rlmtf_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           done,
  input wire logic [rlmtf_pkg::FieldW-1:0]   position,
  input wire logic                           accepted
);
  import rlmtf_pkg::*;

  // a taken command keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy");

  // a result only while a command is in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result word outside a command");

  // the block frees up right after the result word
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("block still busy after result word");

  // a refused push is only ever for an absent key
  a_refuse_absent: assert property (@(posedge clk) disable iff (rst)
    (done && !accepted) |-> (position == '1))
    else $error("refused push reported a listed key");

endmodule

bind recency_list_move_to_front rlmtf_checker u_rlmtf_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .position (position),
  .accepted (accepted)
);

`default_nettype wire

### dv/tb_recency_list_move_to_front.sv
module tb_recency_list_move_to_front;
  timeunit 1ns;
  timeprecision 1ps;

  import rlmtf_pkg::*;

  // cycles with no word moving on either side before the run is abandoned
  localparam int unsigned StallLimit  = 2000;
  // drain time covers the longest command, leave some margin
  localparam int unsigned DrainCycles = 2 * HistoryDepth + 20;
  localparam int unsigned RandomWords = 1030;
  // first phase draws from a smaller pool so the list stays partly filled
  localparam int unsigned SparseWords = 300;
  localparam int unsigned SparsePool  = 48;
  localparam int unsigned KeyPoolSize = 96;
  localparam int unsigned ReportLimit = 10;

  // one expected result word
  typedef struct packed {
    logic signed [FieldW-1:0] position;
    logic [FieldW-1:0]        list_count;
    logic                     accepted;
  } outcome_t;

  // mirrors the list and queues the result word each command should produce
  class recency_scoreboard;
    logic [KeyW-1:0] mru_keys[$];
    outcome_t        expected_words[$];
    int unsigned     faults;

    function void flag(string msg);
      if (faults < ReportLimit) begin
        $display("%0t: %s", $realtime, msg);
      end
      faults++;
    endfunction

    function void note_command(logic op, logic [KeyW-1:0] key);
      int       where;
      outcome_t want;
      where = -1;
      foreach (mru_keys[i]) begin
        if (where < 0 && mru_keys[i] == key) where = i;
      end
      want.accepted = 1'b1;
      if (op == CMD_PUSH) begin
        if (where > 0) begin
          // listed further back: pull it to the front
          mru_keys.delete(where);
          mru_keys.push_front(key);
        end else if (where < 0) begin
          if (mru_keys.size() < HistoryDepth) begin
            mru_keys.push_front(key);
          end else begin
            // full list turns a new key away
            want.accepted = 1'b0;
          end
        end
      end
      want.position   = where[FieldW-1:0];
      want.list_count = FieldW'(mru_keys.size());
      expected_words.push_back(want);
    endfunction

    function void check_word(logic signed [FieldW-1:0] pos, logic [FieldW-1:0] cnt,
                             logic acc);
      outcome_t want;
      if (expected_words.size() == 0) begin
        flag($sformatf("result word with nothing pending: pos %0d count %0d acc %0b",
                       pos, cnt, acc));
        return;
      end
      want = expected_words.pop_front();
      if (pos !== want.position || cnt !== want.list_count || acc !== want.accepted) begin
        flag($sformatf({"mismatch: expected pos %0d count %0d acc %0b, ",
                        "got pos %0d count %0d acc %0b"},
                       $signed(want.position), want.list_count, want.accepted,
                       pos, cnt, acc));
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     cmd = CMD_PUSH;
  logic [KeyW-1:0]          entry_index = '0;
  logic                     done;
  logic signed [FieldW-1:0] position;
  logic [FieldW-1:0]        list_count;
  logic                     accepted;

  recency_scoreboard sb = new();

  logic [KeyW-1:0] key_pool[KeyPoolSize];
  int unsigned     burst_left = 0;
  int unsigned     quiet_cycles = 0;

  recency_list_move_to_front dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .entry_index (entry_index),
    .done        (done),
    .position    (position),
    .list_count  (list_count),
    .accepted    (accepted)
  );

  always #10 clk = ~clk;

  // monitor: values seen here are the ones from before this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_word(position, list_count, accepted);
      if (start && !busy) sb.note_command(cmd, entry_index);
    end
  end

  // watchdog on cycles where no word moves either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold the word on the ports until the block takes it; start stays high
  task automatic send_word(input logic op, input logic [KeyW-1:0] key);
    start       <= 1'b1;
    cmd         <= op;
    entry_index <= key;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // sender works in bursts; a gap of random length opens most new bursts
  task automatic issue(input logic op, input logic [KeyW-1:0] key);
    int unsigned gap;
    int unsigned pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) gap = $urandom_range(1, 4);
      else if (pick < 9) gap = $urandom_range(5, 40);
      else gap = $urandom_range(41, 160);
      // some bursts start straight away
      if ($urandom_range(0, 4) != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    send_word(op, key);
    burst_left--;
  endtask

  initial begin
    logic            op;
    logic [KeyW-1:0] key;
    int unsigned     span;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KeyPoolSize; i++) begin
      key_pool[i] = KeyW'($urandom_range(0, TableSize - 1));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, front hit, moves from inside, absent queries
    issue(CMD_PUSH,  12'h000);  // new key into empty list
    issue(CMD_PUSH,  12'h000);  // already at front
    issue(CMD_PUSH,  12'hfff);
    issue(CMD_QUERY, 12'h000);
    issue(CMD_QUERY, 12'hfff);
    issue(CMD_QUERY, 12'haaa);  // absent
    issue(CMD_PUSH,  12'haaa);
    issue(CMD_PUSH,  12'h555);
    issue(CMD_PUSH,  12'h000);  // move from the back
    issue(CMD_PUSH,  12'hfff);  // move from the back again
    issue(CMD_PUSH,  12'h800);
    issue(CMD_PUSH,  12'h001);
    issue(CMD_QUERY, 12'h555);  // one place before the back
    issue(CMD_PUSH,  12'h555);
    issue(CMD_PUSH,  12'h800);  // move from the middle
    issue(CMD_QUERY, 12'h800);  // query at front
    issue(CMD_QUERY, 12'h7ff);  // absent
    issue(CMD_PUSH,  12'h7ff);
    issue(CMD_PUSH,  12'h7ff);
    issue(CMD_QUERY, 12'h001);

    // random: small pool first, then a pool wider than the list so it fills
    // up and refuses new keys while moves reach every depth
    for (int n = 0; n < RandomWords; n++) begin
      span = (n < SparseWords) ? SparsePool : KeyPoolSize;
      if ($urandom_range(0, 19) == 0) key = KeyW'($urandom_range(0, TableSize - 1));
      else key = key_pool[$urandom_range(0, span - 1)];
      op = ($urandom_range(0, 9) < 3) ? CMD_QUERY : CMD_PUSH;
      issue(op, key);
    end
    start <= 1'b0;

    // drain outstanding results, then look for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/rlmtf_pkg.sv
hdl/recency_list_move_to_front.sv
hdl/rlmtf_checker.sv
dv/tb_recency_list_move_to_front.sv
